// ===== rtl/jfds_pkg.sv =====
// jfds_pkg: shared types, widths and register codes for the frame segmenter
// no dependencies; compiled first
package jfds_pkg;

   // payload widths
   localparam int ADDR_W      = 32;
   localparam int FLEN_W      = 16;
   localparam int BLEN_W      = 15;
   localparam int POS_W       = 10;
   localparam int RSIZE_W     = 11;
   localparam int SEG_CNT_W   = 6;
   localparam int STEP_W      = $clog2(POS_W);

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_RING_SIZE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENHANCED_DESC = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LARGE_BUF     = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SMALL_BUF     = 2'd3;

   // register reset values and limits
   localparam logic [RSIZE_W-1:0] RING_SIZE_RESET  = 11'd256;
   localparam logic [BLEN_W-1:0]  LARGE_BUF_RESET  = 15'd8192;
   localparam logic [BLEN_W-1:0]  SMALL_BUF_RESET  = 15'd2048;
   localparam logic [BLEN_W-1:0]  BUF_BYTES_MAX    = 15'd16384;
   localparam logic [RSIZE_W-1:0] RING_SIZE_MIN    = 11'd2;
   localparam int                 RING_WIDTH_CAP   = 1 << POS_W;
   localparam logic [SEG_CNT_W-1:0] LAST_SEG_COUNT = {SEG_CNT_W{1'b1}};

   // default for the top-level parameter
   localparam int RING_ENTRIES_DEFAULT = 1024;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_EMIT
   } jfds_state_type;

   // controller to datapath
   typedef struct packed {
      logic              load;
      logic              reduce;
      logic [STEP_W-1:0] shift;
      logic              advance;
      logic              commit;
   } jfds_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic in_empty;
      logic pos_high;
      logic last;
   } jfds_status_type;

endpackage

// ===== rtl/jfds_req_if.sv =====
// jfds_req_if: frame request channel (valid/ready plus frame fields)
// depends on jfds_pkg
interface jfds_req_if;
   import jfds_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] frame_address;
   logic [FLEN_W-1:0] frame_length;
   logic              checksum_insert;

   modport source (output valid, frame_address, frame_length, checksum_insert, input ready);
   modport sink   (input valid, frame_address, frame_length, checksum_insert, output ready);
endinterface

// ===== rtl/jfds_rsp_if.sv =====
// jfds_rsp_if: segment descriptor channel (valid/ready plus segment fields)
// depends on jfds_pkg
interface jfds_rsp_if;
   import jfds_pkg::*;

   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  ring_entry;
   logic [ADDR_W-1:0] buffer_address;
   logic [BLEN_W-1:0] buffer_length;
   logic              first_segment;
   logic              set_owner;
   logic              segment_checksum;
   logic              last_segment;

   modport source (output valid, ring_entry, buffer_address, buffer_length, first_segment,
                   set_owner, segment_checksum, last_segment, input ready);
   modport sink   (input valid, ring_entry, buffer_address, buffer_length, first_segment,
                   set_owner, segment_checksum, last_segment, output ready);
endinterface

// ===== rtl/jfds_csr_if.sv =====
// jfds_csr_if: register write channel (valid/ready, index, write data)
// depends on jfds_pkg
interface jfds_csr_if;
   import jfds_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/jfds_datapath.sv =====
// jfds_datapath: config registers, ring position, frame registers, position
// reduction step and per-segment arithmetic; depends on jfds_pkg
module jfds_datapath
   import jfds_pkg::*;
#(
   parameter int MAX_RING_ENTRIES = RING_ENTRIES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // frame fields
   input  logic [ADDR_W-1:0]      req_frame_address,
   input  logic [FLEN_W-1:0]      req_frame_length,
   input  logic                   req_checksum_insert,
   // segment fields
   output logic [POS_W-1:0]       rsp_ring_entry,
   output logic [ADDR_W-1:0]      rsp_buffer_address,
   output logic [BLEN_W-1:0]      rsp_buffer_length,
   output logic                   rsp_first_segment,
   output logic                   rsp_set_owner,
   output logic                   rsp_segment_checksum,
   output logic                   rsp_last_segment,
   // control
   input  jfds_cmd_type           cmd,
   output jfds_status_type        status
);

   localparam int RING_CAP_INT = (MAX_RING_ENTRIES < RING_WIDTH_CAP) ?
                                 MAX_RING_ENTRIES : RING_WIDTH_CAP;
   localparam logic [RSIZE_W-1:0] RING_CAP = RSIZE_W'(RING_CAP_INT);
   localparam int DIV_W = RSIZE_W + POS_W - 1;

   // configuration registers
   logic [RSIZE_W-1:0] ring_size_ff, ring_size_in;
   logic               enhanced_ff, enhanced_in;
   logic [BLEN_W-1:0]  large_buf_ff, large_buf_in;
   logic [BLEN_W-1:0]  small_buf_ff, small_buf_in;
   logic [POS_W-1:0]   ring_position_ff, ring_position_in;

   // frame working registers
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [FLEN_W-1:0]    remaining_ff, remaining_in;
   logic                 csum_ff, csum_in;
   logic [POS_W-1:0]     entry_ff, entry_in;
   logic [SEG_CNT_W-1:0] count_ff, count_in;
   logic [RSIZE_W-1:0]   rsize_ff, rsize_in;
   logic [BLEN_W-1:0]    bmax_ff, bmax_in;

   logic [RSIZE_W-1:0] rsize_eff;
   logic [BLEN_W-1:0]  buf_sel;
   logic [BLEN_W-1:0]  bmax_eff;
   logic [DIV_W-1:0]   div_shifted;
   logic               div_fits;
   logic [BLEN_W-1:0]  seg_len;
   logic [FLEN_W-1:0]  remaining_next;
   logic               seg_last;
   logic [RSIZE_W-1:0] entry_inc;
   logic [POS_W-1:0]   entry_next;

   // effective ring size and buffer size from the registers
   always_comb begin
      if (ring_size_ff < RING_SIZE_MIN) begin
         rsize_eff = RING_SIZE_MIN;
      end else if (ring_size_ff > RING_CAP) begin
         rsize_eff = RING_CAP;
      end else begin
         rsize_eff = ring_size_ff;
      end
      buf_sel = enhanced_ff ? large_buf_ff : small_buf_ff;
      if (buf_sel == '0) begin
         bmax_eff = BLEN_W'(1);
      end else if (buf_sel > BUF_BYTES_MAX) begin
         bmax_eff = BUF_BYTES_MAX;
      end else begin
         bmax_eff = buf_sel;
      end
   end

   // one remainder step: subtract ring size shifted left by the step count
   assign div_shifted = DIV_W'(rsize_ff) << cmd.shift;
   assign div_fits    = DIV_W'(entry_ff) >= div_shifted;

   // current segment and the ring slot after it
   always_comb begin
      seg_len = (remaining_ff > FLEN_W'(bmax_ff)) ? bmax_ff : remaining_ff[BLEN_W-1:0];
      remaining_next = remaining_ff - FLEN_W'(seg_len);
      seg_last = (remaining_next == '0) || (count_ff == LAST_SEG_COUNT);
      entry_inc = RSIZE_W'(entry_ff) + RSIZE_W'(1);
      entry_next = (entry_inc >= rsize_ff) ? '0 : entry_inc[POS_W-1:0];
   end

   // register writes and position commit
   always_comb begin
      ring_size_in     = ring_size_ff;
      enhanced_in      = enhanced_ff;
      large_buf_in     = large_buf_ff;
      small_buf_in     = small_buf_ff;
      ring_position_in = ring_position_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RING_SIZE:     ring_size_in = csr_wdata[RSIZE_W-1:0];
            CSR_ENHANCED_DESC: enhanced_in  = csr_wdata[0];
            CSR_LARGE_BUF:     large_buf_in = csr_wdata[BLEN_W-1:0];
            CSR_SMALL_BUF:     small_buf_in = csr_wdata[BLEN_W-1:0];
            default: ;
         endcase
      end
      if (cmd.commit) begin
         ring_position_in = entry_next;
      end
   end

   // frame registers: load, reduce, advance
   always_comb begin
      addr_in      = addr_ff;
      remaining_in = remaining_ff;
      csum_in      = csum_ff;
      entry_in     = entry_ff;
      count_in     = count_ff;
      rsize_in     = rsize_ff;
      bmax_in      = bmax_ff;
      if (cmd.load) begin
         addr_in      = req_frame_address;
         remaining_in = req_frame_length;
         csum_in      = req_checksum_insert;
         entry_in     = ring_position_ff;
         count_in     = '0;
         rsize_in     = rsize_eff;
         bmax_in      = bmax_eff;
      end else if (cmd.reduce) begin
         if (div_fits) begin
            entry_in = entry_ff - div_shifted[POS_W-1:0];
         end
      end else if (cmd.advance) begin
         addr_in      = addr_ff + ADDR_W'(bmax_ff);
         remaining_in = remaining_next;
         entry_in     = entry_next;
         count_in     = count_ff + SEG_CNT_W'(1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff     <= RING_SIZE_RESET;
         enhanced_ff      <= 1'b0;
         large_buf_ff     <= LARGE_BUF_RESET;
         small_buf_ff     <= SMALL_BUF_RESET;
         ring_position_ff <= '0;
      end else begin
         ring_size_ff     <= ring_size_in;
         enhanced_ff      <= enhanced_in;
         large_buf_ff     <= large_buf_in;
         small_buf_ff     <= small_buf_in;
         ring_position_ff <= ring_position_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      remaining_ff <= remaining_in;
      csum_ff      <= csum_in;
      entry_ff     <= entry_in;
      count_ff     <= count_in;
      rsize_ff     <= rsize_in;
      bmax_ff      <= bmax_in;
   end

   // status and segment fields
   assign status.in_empty = (req_frame_length == '0);
   assign status.pos_high = RSIZE_W'(ring_position_ff) >= rsize_eff;
   assign status.last     = seg_last;

   assign rsp_ring_entry       = entry_ff;
   assign rsp_buffer_address   = addr_ff;
   assign rsp_buffer_length    = seg_len;
   assign rsp_first_segment    = (count_ff == '0);
   assign rsp_set_owner        = (count_ff != '0);
   assign rsp_segment_checksum = csum_ff;
   assign rsp_last_segment     = seg_last;

endmodule

// ===== rtl/jfds_controller.sv =====
// jfds_controller: frame sequencing state machine (accept, reduce, emit)
// depends on jfds_pkg
module jfds_controller
   import jfds_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  jfds_status_type status,
   output jfds_cmd_type    cmd
);

   localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(POS_W - 1);

   jfds_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd         = '0;
      cmd.shift   = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.in_empty) begin
                  state_in = ST_IDLE;
               end else if (status.pos_high) begin
                  state_in = ST_REDUCE;
                  step_in  = STEP_FIRST;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            if (step_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (status.last) begin
                  cmd.commit = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/jumbo_frame_descriptor_segmenter_unit.sv =====
// sequence: accept beat; for a non-empty frame a remainder reduction only when the stored
// ring position is not below the ring size, then one segment beat per cycle while ready is high
// a new frame is accepted only in idle, after the last segment beat of the previous one
// reset: synchronous, active high; registers to defaults, ring position 0
// depends on jfds_pkg, jfds_req_if, jfds_rsp_if, jfds_csr_if, jfds_controller, jfds_datapath
module jumbo_frame_descriptor_segmenter_unit
   import jfds_pkg::*;
#(
   parameter int MAX_RING_ENTRIES = RING_ENTRIES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   jfds_req_if.sink   req_chan,
   jfds_rsp_if.source rsp_chan,
   jfds_csr_if.sink   csr_chan
);

   jfds_cmd_type    cmd;
   jfds_status_type status;
   logic            req_ready;
   logic            rsp_valid;

   // register writes always taken
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   jfds_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   jfds_datapath #(
      .MAX_RING_ENTRIES (MAX_RING_ENTRIES)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_chan.valid),
      .csr_index            (csr_chan.index),
      .csr_wdata            (csr_chan.wdata),
      .req_frame_address    (req_chan.frame_address),
      .req_frame_length     (req_chan.frame_length),
      .req_checksum_insert  (req_chan.checksum_insert),
      .rsp_ring_entry       (rsp_chan.ring_entry),
      .rsp_buffer_address   (rsp_chan.buffer_address),
      .rsp_buffer_length    (rsp_chan.buffer_length),
      .rsp_first_segment    (rsp_chan.first_segment),
      .rsp_set_owner        (rsp_chan.set_owner),
      .rsp_segment_checksum (rsp_chan.segment_checksum),
      .rsp_last_segment     (rsp_chan.last_segment),
      .cmd                  (cmd),
      .status               (status)
   );

endmodule

// ===== rtl/jfds_checker.sv =====
// jfds_checker: port-level assertions for the segmenter, bound to the top level
// depends on jfds_pkg and jumbo_frame_descriptor_segmenter_unit
module jfds_checker
   import jfds_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [POS_W-1:0]  rsp_ring_entry,
   input logic [ADDR_W-1:0] rsp_buffer_address,
   input logic [BLEN_W-1:0] rsp_buffer_length,
   input logic              rsp_first_segment,
   input logic              rsp_set_owner,
   input logic              rsp_last_segment
);

   // a stalled segment beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_buffer_address)
         && $stable(rsp_ring_entry) && $stable(rsp_buffer_length)))
      else $error("segment beat changed while stalled");

   // no new frame taken while segments are pending
   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("frame accepted during segment output");

   // segment length within the buffer limits
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_buffer_length != '0 && rsp_buffer_length <= BUF_BYTES_MAX))
      else $error("segment length out of range");

   // a non-final beat is followed directly by an owned continuation beat
   a_continue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_segment) |=>
         (rsp_valid && !rsp_first_segment && rsp_set_owner))
      else $error("frame run broken after non-final segment");

endmodule

bind jumbo_frame_descriptor_segmenter_unit jfds_checker u_jfds_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_ring_entry     (rsp_chan.ring_entry),
   .rsp_buffer_address (rsp_chan.buffer_address),
   .rsp_buffer_length  (rsp_chan.buffer_length),
   .rsp_first_segment  (rsp_chan.first_segment),
   .rsp_set_owner      (rsp_chan.set_owner),
   .rsp_last_segment   (rsp_chan.last_segment)
);

// ===== bench/jumbo_frame_descriptor_segmenter_unit_tb.sv =====
// self-checking bench for the frame segmenter: drives frames and register writes,
// predicts every segment descriptor and compares each returned beat in order
// depends on jfds_pkg, jfds_req_if, jfds_rsp_if, jfds_csr_if and the segmenter top
`timescale 1ns / 100ps

module jumbo_frame_descriptor_segmenter_unit_tb;
   import jfds_pkg::*;

   localparam int RING_ENTRIES  = RING_ENTRIES_DEFAULT;
   localparam int SEGMENT_LIMIT = 1 << SEG_CNT_W;
   localparam int MAX_REPORTS   = 10;
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 49;

   typedef struct packed {
      logic [POS_W-1:0]  ring_entry;
      logic [ADDR_W-1:0] buffer_address;
      logic [BLEN_W-1:0] buffer_length;
      logic              first_segment;
      logic              set_owner;
      logic              segment_checksum;
      logic              last_segment;
   } segment_desc_type;

   // predicts the descriptor run of each frame and holds the ones not yet seen
   class ring_segment_tracker;
      logic [RSIZE_W-1:0] ring_size;
      logic               enhanced;
      logic [BLEN_W-1:0]  large_bytes;
      logic [BLEN_W-1:0]  small_bytes;
      logic [POS_W-1:0]   position;
      int unsigned        ring_cap;
      int unsigned        failures;
      segment_desc_type   pending[$];

      function new(int unsigned max_entries);
         ring_cap    = (max_entries < RING_WIDTH_CAP) ? max_entries : RING_WIDTH_CAP;
         ring_size   = RING_SIZE_RESET;
         enhanced    = 1'b0;
         large_bytes = LARGE_BUF_RESET;
         small_bytes = SMALL_BUF_RESET;
         position    = '0;
         failures    = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_RING_SIZE:     ring_size   = data[RSIZE_W-1:0];
            CSR_ENHANCED_DESC: enhanced    = data[0];
            CSR_LARGE_BUF:     large_bytes = data[BLEN_W-1:0];
            CSR_SMALL_BUF:     small_bytes = data[BLEN_W-1:0];
            default: ;
         endcase
      endfunction

      // active buffer size, clamped to 1..16384
      function int unsigned buffer_bytes();
         int unsigned b;
         b = enhanced ? large_bytes : small_bytes;
         if (b == 0) b = 1;
         if (b > BUF_BYTES_MAX) b = BUF_BYTES_MAX;
         return b;
      endfunction

      // accepted frame: queue one descriptor per segment and move the ring
      function void note_frame(logic [ADDR_W-1:0] addr, logic [FLEN_W-1:0] len, logic csum);
         int unsigned       rsize;
         int unsigned       bmax;
         int unsigned       entry;
         int unsigned       remaining;
         int unsigned       seg_len;
         int                count;
         logic [ADDR_W-1:0] cur;
         segment_desc_type  seg;
         rsize = ring_size;
         if (rsize < RING_SIZE_MIN) rsize = RING_SIZE_MIN;
         if (rsize > ring_cap) rsize = ring_cap;
         bmax = buffer_bytes();
         entry = position % rsize;
         if (len == 0) return;
         remaining = len;
         count = 0;
         cur = addr;
         while (remaining != 0 && count < SEGMENT_LIMIT) begin
            seg_len = (remaining > bmax) ? bmax : remaining;
            remaining = remaining - seg_len;
            seg.ring_entry       = POS_W'(entry);
            seg.buffer_address   = cur;
            seg.buffer_length    = BLEN_W'(seg_len);
            seg.first_segment    = (count == 0);
            seg.set_owner        = (count != 0);
            seg.segment_checksum = csum;
            seg.last_segment     = (remaining == 0) || (count == SEGMENT_LIMIT - 1);
            pending.push_back(seg);
            cur = cur + ADDR_W'(bmax);
            entry++;
            if (entry >= rsize) entry = 0;
            count++;
         end
         position = POS_W'(entry);
      endfunction

      function bit count_failure();
         failures++;
         return failures <= MAX_REPORTS;
      endfunction

      // returned beat against the oldest expected descriptor
      function void check_segment(segment_desc_type got);
         segment_desc_type want;
         if (pending.size() == 0) begin
            if (count_failure())
               $display("unexpected: entry %0d addr %h len %0d first %b owner %b csum %b last %b",
                        got.ring_entry, got.buffer_address, got.buffer_length, got.first_segment,
                        got.set_owner, got.segment_checksum, got.last_segment);
            return;
         end
         want = pending.pop_front();
         if (got.ring_entry !== want.ring_entry || got.buffer_address !== want.buffer_address ||
             got.buffer_length !== want.buffer_length ||
             got.first_segment !== want.first_segment || got.set_owner !== want.set_owner ||
             got.segment_checksum !== want.segment_checksum ||
             got.last_segment !== want.last_segment) begin
            if (count_failure()) begin
               $display("expected: entry %0d addr %h len %0d first %b owner %b csum %b last %b",
                        want.ring_entry, want.buffer_address, want.buffer_length,
                        want.first_segment, want.set_owner, want.segment_checksum,
                        want.last_segment);
               $display("actual:   entry %0d addr %h len %0d first %b owner %b csum %b last %b",
                        got.ring_entry, got.buffer_address, got.buffer_length, got.first_segment,
                        got.set_owner, got.segment_checksum, got.last_segment);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;

   jfds_req_if req_chan ();
   jfds_rsp_if rsp_chan ();
   jfds_csr_if csr_chan ();

   ring_segment_tracker tracker;

   jumbo_frame_descriptor_segmenter_unit #(
      .MAX_RING_ENTRIES(RING_ENTRIES)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // result side back-pressure
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         int gap;
         gap = pick_gap();
         if (gap == 0) begin
            @(negedge clock) rsp_chan.ready = 1'b1;
         end else begin
            @(negedge clock) rsp_chan.ready = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      segment_desc_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.ring_entry       = rsp_chan.ring_entry;
         got.buffer_address   = rsp_chan.buffer_address;
         got.buffer_length    = rsp_chan.buffer_length;
         got.first_segment    = rsp_chan.first_segment;
         got.set_owner        = rsp_chan.set_owner;
         got.segment_checksum = rsp_chan.segment_checksum;
         got.last_segment     = rsp_chan.last_segment;
         tracker.check_segment(got);
      end
   end

   // run limit
   initial begin
      #100_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   task automatic send_frame(input logic [ADDR_W-1:0] addr, input logic [FLEN_W-1:0] len,
                             input logic csum);
      @(negedge clock);
      req_chan.valid           = 1'b1;
      req_chan.frame_address   = addr;
      req_chan.frame_length    = len;
      req_chan.checksum_insert = csum;
      do @(posedge clock); while (!req_chan.ready);
      tracker.note_frame(addr, len, csum);
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock) req_chan.valid = 1'b0;
      end
   endtask

   // sender holds off until every predicted segment has come back
   task automatic wait_for_results();
      @(negedge clock) req_chan.valid = 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
   endtask

   // drained and quiet, so registers may change
   task automatic settle_block();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_chan.valid = 1'b1;
      csr_chan.index = idx;
      csr_chan.wdata = data;
      do @(posedge clock); while (!csr_chan.ready);
      tracker.write_register(idx, data);
      @(negedge clock) csr_chan.valid = 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] random_ring_size();
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 1;
         2: v = 2;
         3: v = 1024;
         4: v = $urandom_range(1025, 2047);
         5, 6: v = $urandom_range(2, 16);
         default: v = $urandom_range(2, 1024);
      endcase
      return {5'($urandom), 11'(v)};
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_buffer_size();
      int v;
      case ($urandom_range(0, 9))
         0: v = 0;
         1: v = 1;
         2: v = 16384;
         3: v = $urandom_range(16385, 32767);
         4, 5, 6: v = $urandom_range(1, 64);
         7, 8: v = $urandom_range(65, 16384);
         default: v = $urandom_range(0, 1) ? 2048 : 8192;
      endcase
      return {1'($urandom), 15'(v)};
   endfunction

   task automatic randomize_registers();
      write_register(CSR_RING_SIZE, random_ring_size());
      write_register(CSR_ENHANCED_DESC, 16'($urandom));
      write_register(CSR_LARGE_BUF, random_buffer_size());
      write_register(CSR_SMALL_BUF, random_buffer_size());
   endtask

   function automatic logic [ADDR_W-1:0] random_address();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 32'hFFFF_FFFF - $urandom_range(0, 65535);
      if (r < 14) return '0;
      return $urandom;
   endfunction

   // short frames most often, with empty, exact-multiple, full-range and near-maximum lengths mixed in
   function automatic logic [FLEN_W-1:0] random_length();
      int unsigned bmax;
      int unsigned top;
      int          r;
      bmax = tracker.buffer_bytes();
      r = $urandom_range(0, 99);
      if (r < 4) return '0;
      if (r < 50) begin
         top = (bmax * 3 > 65535) ? 65535 : bmax * 3;
         return FLEN_W'($urandom_range(1, top));
      end
      if (r < 62) return FLEN_W'(bmax * $urandom_range(1, 65535 / bmax));
      if (r < 90) return FLEN_W'($urandom_range(1, 65535));
      return FLEN_W'($urandom_range(60000, 65535));
   endfunction

   // stimulus
   initial begin
      int pause_at;
      tracker = new(RING_ENTRIES);
      steady = 1'b0;
      reset = 1'b1;
      req_chan.valid           = 1'b0;
      req_chan.frame_address   = '0;
      req_chan.frame_length    = '0;
      req_chan.checksum_insert = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = CSR_RING_SIZE;
      csr_chan.wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock) reset = 1'b0;

      // reset settings: short, exact, split, empty and address-wrapping frames
      send_frame(32'h0000_0000, 16'd1, 1'b0);
      send_frame(32'hFFFF_FFFF, 16'd65535, 1'b1);
      send_frame(32'h0000_1000, 16'd2048, 1'b1);
      send_frame(32'h0000_2000, 16'd2049, 1'b0);
      send_frame(32'h0000_3000, 16'd0, 1'b1);
      send_frame(32'hFFFF_F000, 16'd10000, 1'b0);

      // one-byte buffers on a tiny ring: segment cap and ring wrap
      settle_block();
      write_register(CSR_RING_SIZE, 16'd3);
      write_register(CSR_ENHANCED_DESC, 16'd1);
      write_register(CSR_LARGE_BUF, 16'd1);
      write_register(CSR_SMALL_BUF, 16'd0);
      send_frame(32'h55AA_55AA, 16'd100, 1'b1);
      send_frame(32'hAA55_AA54, 16'd64, 1'b0);
      send_frame(32'h0000_0010, 16'd65, 1'b1);

      // ring size below the minimum, buffer size above the maximum
      settle_block();
      write_register(CSR_RING_SIZE, 16'd0);
      write_register(CSR_LARGE_BUF, 16'd20000);
      send_frame(32'h8000_0000, 16'd65535, 1'b1);
      send_frame(32'h7FFF_FFFF, 16'd16384, 1'b0);

      // zero small buffer on an oversized ring, walk the position up
      settle_block();
      write_register(CSR_ENHANCED_DESC, 16'd0);
      write_register(CSR_RING_SIZE, 16'h07FF);
      for (int k = 0; k < 8; k++)
         send_frame(32'h0010_0000 * k, 16'd64, k[0]);

      // shrink the ring under a stale position
      settle_block();
      write_register(CSR_RING_SIZE, 16'd5);
      write_register(CSR_SMALL_BUF, 16'd16384);
      send_frame(32'h1234_5678, 16'd1, 1'b1);
      send_frame(32'h9ABC_DEF0, 16'd40000, 1'b0);

      // random phases, each with fresh register settings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_block();
         randomize_registers();
         steady = (phase == 2);
         pause_at = $urandom_range(0, PHASE_ITEMS - 1);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == pause_at) wait_for_results();
            send_frame(random_address(), random_length(), 1'($urandom));
            idle_sender(pick_gap());
         end
      end
      steady = 1'b0;

      settle_block();
      if (tracker.pending.size() != 0) begin
         if (tracker.count_failure())
            $display("%0d expected segments never returned", tracker.pending.size());
      end
      if (tracker.failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/jfds_pkg.sv
rtl/jfds_req_if.sv
rtl/jfds_rsp_if.sv
rtl/jfds_csr_if.sv
rtl/jfds_datapath.sv
rtl/jfds_controller.sv
rtl/jumbo_frame_descriptor_segmenter_unit.sv
rtl/jfds_checker.sv
bench/jumbo_frame_descriptor_segmenter_unit_tb.sv
